// ===== rtl/maxlog_llr_soft_demapper_unit_defines.svh =====
// Assertion macros for the max-log LLR soft demapper
`ifndef MAXLOG_LLR_SOFT_DEMAPPER_UNIT_DEFINES_SVH
`define MAXLOG_LLR_SOFT_DEMAPPER_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MLD_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define MLD_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/mld_pkg.sv =====
// Package: constellation tables and codes for the soft demapper
`default_nettype none
package mld_pkg;
    localparam int MAX_POINTS_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int LLR_W            = 16;
    localparam int VAR_W            = 16;
    localparam int MOD_W            = 3;
    localparam int BITPOS_W         = 3;
    localparam int MAX_BITS         = 6;

    localparam logic [MOD_W-1:0] MODE_BPSK  = 3'd0;
    localparam logic [MOD_W-1:0] MODE_QPSK  = 3'd1;
    localparam logic [MOD_W-1:0] MODE_QAM64 = 3'd5;

    localparam logic [0:0] REG_MODULATION = 1'b0;
    localparam logic [0:0] REG_VAR_FLOOR  = 1'b1;

    function automatic logic [7:0] qam_code(input logic [6:0] idx);
        logic [3:0] ci;
        logic [3:0] cq;
        logic [5:0] p;
        ci = 4'd0;
        cq = 4'd0;
        p = 6'd0;
        if (idx >= 7'd14 && idx < 7'd30)
        begin
            p = 6'(idx - 7'd14);
            case (p[3:2])
                2'd0: ci = -4'sd3;
                2'd1: ci = -4'sd1;
                2'd2: ci = 4'sd3;
                default: ci = 4'sd1;
            endcase
            case (p[1:0])
                2'd0: cq = 4'sd3;
                2'd1: cq = 4'sd1;
                2'd2: cq = -4'sd3;
                default: cq = -4'sd1;
            endcase
        end
        else if (idx >= 7'd30 && idx < 7'd62)
        begin
            p = 6'(idx - 7'd30);
            if (p[3] == 1'b0)
            begin
                case (p[2:0])
                    3'd0: begin ci = 4'sd3; cq = 4'sd5; end
                    3'd1: begin ci = 4'sd1; cq = 4'sd5; end
                    3'd2: begin ci = 4'sd3; cq = -4'sd5; end
                    3'd3: begin ci = 4'sd1; cq = -4'sd5; end
                    3'd4: begin ci = 4'sd5; cq = 4'sd3; end
                    3'd5: begin ci = 4'sd5; cq = 4'sd1; end
                    3'd6: begin ci = 4'sd5; cq = -4'sd3; end
                    default: begin ci = 4'sd5; cq = -4'sd1; end
                endcase
            end
            else
            begin
                ci = p[2] ? 4'sd3 : 4'sd1;
                case (p[1:0])
                    2'd0: cq = 4'sd3;
                    2'd1: cq = 4'sd1;
                    2'd2: cq = -4'sd3;
                    default: cq = -4'sd1;
                endcase
            end
            if (p[4] == 1'b0)
                ci = -ci;
        end
        else if (idx >= 7'd62)
        begin
            p = 6'(idx - 7'd62);
            case (p[4:3])
                2'd0: ci = 4'sd7;
                2'd1: ci = 4'sd5;
                2'd2: ci = 4'sd1;
                default: ci = 4'sd3;
            endcase
            if (p[5] == 1'b0)
                ci = -ci;
            case (p[1:0])
                2'd0: cq = 4'sd7;
                2'd1: cq = 4'sd5;
                2'd2: cq = 4'sd1;
                default: cq = 4'sd3;
            endcase
            if (p[2])
                cq = -cq;
        end
        return {ci, cq};
    endfunction

    // signed coordinate codes, 4 bits each
    function automatic logic [7:0] pts_code(input logic [6:0] idx);
        logic [7:0] r;
        case (idx)
            7'd0: r = {4'sd1, 4'sd0};     7'd1: r = {-4'sd1, 4'sd0};
            7'd2: r = {-4'sd1, 4'sd1};    7'd3: r = {-4'sd1, -4'sd1};
            7'd4: r = {4'sd1, 4'sd1};     7'd5: r = {4'sd1, -4'sd1};
            7'd6: r = {-4'sd1, -4'sd1};   7'd7: r = {-4'sd2, 4'sd0};
            7'd8: r = {4'sd0, 4'sd2};     7'd9: r = {-4'sd1, 4'sd1};
            7'd10: r = {4'sd0, -4'sd2};   7'd11: r = {4'sd1, -4'sd1};
            7'd12: r = {4'sd1, 4'sd1};    7'd13: r = {4'sd2, 4'sd0};
            default: r = qam_code(idx);
        endcase
        return r;
    endfunction

    // Q1.13 level for a code magnitude
    function automatic logic [13:0] level(input logic [2:0] md, input logic [2:0] mag);
        logic [13:0] r;
        r = 14'd0;
        case (md)
            3'd0: if (mag == 3'd1) r = 14'd8192;
            3'd1: if (mag == 3'd1) r = 14'd5793;
            3'd2: if (mag == 3'd1) r = 14'd5793; else if (mag == 3'd2) r = 14'd8192;
            3'd3: if (mag == 3'd1) r = 14'd2591; else if (mag == 3'd3) r = 14'd7772;
            3'd4:
            begin
                if (mag == 3'd1) r = 14'd1832;
                else if (mag == 3'd3) r = 14'd5495;
                else if (mag == 3'd5) r = 14'd9159;
            end
            3'd5:
            begin
                if (mag == 3'd1) r = 14'd1264;
                else if (mag == 3'd3) r = 14'd3792;
                else if (mag == 3'd5) r = 14'd6320;
                else if (mag == 3'd7) r = 14'd8848;
            end
            default: r = 14'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/maxlog_llr_soft_demapper_unit.sv =====
// Top level: max-log LLR soft demapper with minimum-distance memory
// Usage:
//   Write modulation (index 0) and variance_floor (index 1) through cfg_we
//   while idle. Raise start with i_sample, q_sample, noise_variance; the
//   transaction is taken at an edge where busy is low. The block walks every
//   constellation point, one per cycle, through a three-stage distance
//   pipeline; per-bit minima live in a small memory updated by
//   read-modify-write. Each bit's LLR then comes from a restoring divider of
//   NUMW steps (34 at SAMPLE_WIDTH 16), MSB first. Each LLR shows for one
//   cycle with llr_valid; last_bit marks the final. Busy covers the walk,
//   the drain, and the read and divide of every bit; busy falls with the
//   last LLR.
//   Reset: modulation QPSK (BPSK if MAX_POINTS < 4), floor 4, idle.
//   The receiver cannot stall; no clearing pass is needed since the
//   minima are initialized by the first point's write.
`default_nettype none
`include "maxlog_llr_soft_demapper_unit_defines.svh"
module maxlog_llr_soft_demapper_unit
    import mld_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [VAR_W-1:0]               cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
    input  wire logic [VAR_W-1:0]               noise_variance,
    output logic                                llr_valid,
    output logic signed [LLR_W-1:0]             llr,
    output logic [BITPOS_W-1:0]                 bit_position,
    output logic                                last_bit
);
    localparam int DW    = 2 * SAMPLE_WIDTH + 2;
    localparam int SH    = 2 * SAMPLE_WIDTH - 26;
    localparam int NUMW  = DW + ((SH < 0) ? -SH : 0);
    localparam int DENW  = VAR_W + ((SH > 0) ? SH : 0);
    localparam int QW    = NUMW;
    localparam int EW    = SAMPLE_WIDTH + 2;
    localparam int CW    = EW + 15;
    localparam int UP_SH = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
    localparam int DN_SH = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 1;

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_RD, S_RDW, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [VAR_W-1:0] floor_reg;
    logic signed [SAMPLE_WIDTH-1:0] xi_reg, xq_reg;
    logic [VAR_W-1:0] var_reg;
    logic [6:0] pcnt_reg;
    logic [2:0] drain_reg;
    logic [2:0] bit_reg;

    // config
    logic [MOD_W-1:0] cv;
    assign cv = cfg_data[MOD_W-1:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= (MAX_POINTS >= 4) ? MODE_QPSK : MODE_BPSK;
            floor_reg <= VAR_W'(4);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODULATION)
            begin
                if (cv <= MODE_QAM64 && (32'd2 << cv) <= 32'(MAX_POINTS))
                    mod_reg <= cv;
            end
            else
                floor_reg <= cfg_data;
        end
    end

    logic [6:0] npts, base;
    assign npts = 7'd2 << mod_reg;
    assign base = npts - 7'd2;

    // stage 1: coordinates
    logic        s1_v, s2_v, s3_v;
    logic [5:0]  s1_p, s2_p, s3_p;
    logic signed [EW-1:0] s1_ci, s1_cq;
    logic [7:0] code;
    assign code = pts_code(7'(base + pcnt_reg));

    function automatic logic signed [EW-1:0] coordf(input logic [2:0] md,
                                                   input logic [3:0] c);
        logic [2:0] mg;
        logic [13:0] lv;
        logic signed [CW-1:0] v;
        mg = c[3] ? 3'(-c) : c[2:0];
        lv = level(md, mg);
        if (SAMPLE_WIDTH >= 16)
            v = CW'(lv) <<< UP_SH;
        else
            v = (CW'(lv) + (CW'(1) <<< (DN_SH - 1))) >>> DN_SH;
        return c[3] ? -EW'(v) : EW'(v);
    endfunction

    // stage 2: absolute differences; stage 3: squares summed
    logic [EW-1:0] s2_ai, s2_aq;
    logic [DW-1:0] s3_d;
    logic signed [EW-1:0] di, dq;
    assign di = EW'(xi_reg) - s1_ci;
    assign dq = EW'(xq_reg) - s1_cq;

    always_ff @(posedge clk)
    begin
        s1_ci <= coordf(mod_reg, code[7:4]);
        s1_cq <= coordf(mod_reg, code[3:0]);
        s1_p  <= pcnt_reg[5:0];
        s2_ai <= di[EW-1] ? EW'(-di) : EW'(di);
        s2_aq <= dq[EW-1] ? EW'(-dq) : EW'(dq);
        s2_p  <= s1_p;
        s3_d  <= DW'(s2_ai) * DW'(s2_ai) + DW'(s2_aq) * DW'(s2_aq);
        s3_p  <= s2_p;
    end

    // minima memory: entry {bit,value}, 12 entries, per-entry RMW across 6 bits.
    // Held as registers read at fixed places per bit lane.
    logic [DW-1:0] dmin_mem [2*MAX_BITS];
    always_ff @(posedge clk)
    begin
        if (s3_v)
        begin
            for (int k = 0; k < MAX_BITS; k++)
            begin
                if (s3_p[k])
                begin
                    if (s3_p == 6'(1 << k) || s3_d < dmin_mem[4'(2*k+1)])
                        dmin_mem[4'(2*k+1)] <= s3_d;
                end
                else if (s3_p == 6'd0 || s3_d < dmin_mem[4'(2*k)])
                    dmin_mem[4'(2*k)] <= s3_d;
            end
        end
    end

    // divider
    logic [QW-1:0] q_reg;
    logic [NUMW-1:0] num_reg;
    logic [DENW:0] rem_reg;
    logic [DENW-1:0] den;
    logic neg_reg;
    logic [5:0] dcnt_reg;
    logic [DW-1:0] d0_reg, d1_reg;
    logic [DENW:0] rem_sh;
    assign den = (SH > 0) ? DENW'(var_reg) << ((SH > 0) ? SH : 0) : DENW'(var_reg);
    assign rem_sh = {rem_reg[DENW-1:0], num_reg[NUMW-1]};

    logic [QW:0] qr;
    logic [DENW+1:0] rem2;
    assign rem2 = {rem_reg, 1'b0};
    assign qr = (QW+1)'(q_reg) + ((rem2 >= (DENW+2)'(den)) ? (QW+1)'(1) : '0);

    logic [VAR_W-1:0] v_eff;
    always_comb
    begin
        v_eff = (noise_variance < floor_reg) ? floor_reg : noise_variance;
        if (v_eff == '0)
            v_eff = VAR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
            llr_valid <= 1'b0;
            last_bit <= 1'b0;
            llr <= '0;
            bit_position <= '0;
            xi_reg <= '0; xq_reg <= '0; var_reg <= '0;
            d0_reg <= '0; d1_reg <= '0; neg_reg <= 1'b0;
            num_reg <= '0; rem_reg <= '0; q_reg <= '0;
            pcnt_reg <= '0; drain_reg <= '0; bit_reg <= '0; dcnt_reg <= '0;
        end
        else
        begin
            s2_v <= s1_v;
            s3_v <= s2_v;
            s1_v <= 1'b0;
            llr_valid <= 1'b0;
            last_bit <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        xi_reg <= i_sample;
                        xq_reg <= q_sample;
                        var_reg <= v_eff;
                        pcnt_reg <= '0;
                        state_reg <= S_WALK;
                    end
                S_WALK:
                begin
                    s1_v <= 1'b1;
                    pcnt_reg <= pcnt_reg + 7'd1;
                    if (pcnt_reg == npts - 7'd1)
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 3'd1;
                    if (drain_reg == 3'd3)
                    begin
                        bit_reg <= mod_reg;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    d0_reg <= dmin_mem[{bit_reg, 1'b0}];
                    d1_reg <= dmin_mem[{bit_reg, 1'b1}];
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    neg_reg <= d1_reg < d0_reg;
                    num_reg <= NUMW'((d1_reg < d0_reg) ? d0_reg - d1_reg : d1_reg - d0_reg)
                               << ((SH < 0) ? -SH : 0);
                    rem_reg <= '0;
                    q_reg <= '0;
                    dcnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= (DENW+1)'(den))
                    begin
                        rem_reg <= rem_sh - (DENW+1)'(den);
                        q_reg <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg <= {q_reg[QW-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'(NUMW - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    llr_valid <= 1'b1;
                    bit_position <= bit_reg;
                    if (neg_reg)
                        llr <= (qr > (QW+1)'(32768)) ? 16'sh8000 : -LLR_W'(qr);
                    else
                        llr <= (qr > (QW+1)'(32767)) ? 16'sh7fff : LLR_W'(qr);
                    if (bit_reg == '0)
                    begin
                        last_bit <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                        state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MLD_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `MLD_ASSERT_IMP(a_last_valid, clk, rst_n, last_bit, llr_valid)
    `MLD_ASSERT_IMP(a_last_bit0, clk, rst_n, last_bit, bit_position == '0)
    `MLD_ASSERT_IMP(a_walk_nout, clk, rst_n, s1_v || s3_v, !llr_valid)
endmodule
`default_nettype wire
